// ----- hw/rtl/ltgs_pkg.sv -----
package ltgs_pkg;

    // Widths of the item fields.
    localparam int unsigned TILE_W    = 16;
    localparam int unsigned BORDER_W  = 8;
    localparam int unsigned CORNER_W  = 4;
    localparam int unsigned MASK_W    = 8;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DAT_W = 8;
    localparam int unsigned COUNT_W   = 4;

    // Item operations.
    typedef enum logic
    {
        OP_LOAD = 1'b0,
        OP_STEP = 1'b1
    } op_t;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SURVIVE_MASK  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BIRTH_MASK    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SURVIVE_ALONE = 2'd2;

    // Reset values of the rule registers.
    localparam logic [MASK_W-1:0] SURVIVE_MASK_RST  = 8'b0000_0110;
    localparam logic [MASK_W-1:0] BIRTH_MASK_RST    = 8'b0000_0100;
    localparam logic              SURVIVE_ALONE_RST = 1'b0;

    // One input item.
    typedef struct packed
    {
        op_t                 op;
        logic [TILE_W-1:0]   load_cells;
        logic [BORDER_W-1:0] north_south;
        logic [BORDER_W-1:0] east_west;
        logic [CORNER_W-1:0] corners;
    } in_item_t;

    // One result item.
    typedef struct packed
    {
        logic [TILE_W-1:0] cells;
        logic              all_dead;
        logic              unchanged;
    } out_item_t;

endpackage

// ----- hw/rtl/ltgs_if.sv -----
// Channel that carries input items into the tile unit.
interface ltgs_req_if
(
    input logic clk
);
    logic               valid;
    logic               ready;
    ltgs_pkg::in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// Channel that carries result items out of the tile unit.
interface ltgs_rsp_if
(
    input logic clk
);
    logic                valid;
    logic                ready;
    ltgs_pkg::out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/life_tile_generation_step_unit.sv -----
// Life tile generation step unit.
// Holds one 4x4 tile of a life automaton, bit 4*row+col set for a live cell.
// Channel req brings items: a load item replaces the tile with load_cells, a
// step item brings the twenty border cells and advances the tile by one
// generation under the survive, birth and survive-alone rules.
// Channel rsp returns one item per request: the new tile, an all-dead flag
// and an unchanged flag. A transfer happens when valid and ready are both high.
// The rule registers are written through cfg_we, cfg_index and cfg_wdata; the
// user must write them only while no item is in flight, and the block does
// not enforce this. Writes to unknown indexes are dropped.
// An item passes from the input register through the neighbor counts into
// the result register, which drives rsp valid.
// Throughput is one item per cycle while the receiver does not stall; the
// tile register is updated in the same cycle the result register loads, so
// each item sees the previous result.
// When the receiver stalls, the result register holds and the input register
// fills; req.ready then drops until rsp.ready returns.
// Reset clears the tile to all dead, empties both stages and restores the
// rule registers to their default values.
module life_tile_generation_step_unit
(
    input  logic                              clk,
    input  logic                              rst_n,
    ltgs_req_if.sink                          req,
    ltgs_rsp_if.source                        rsp,
    input  logic                              cfg_we,
    input  logic [ltgs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ltgs_pkg::CFG_DAT_W-1:0]    cfg_wdata
);

    logic                              s1_valid_reg;
    ltgs_pkg::in_item_t                s1_item_reg;
    logic                              rsp_valid_reg;
    ltgs_pkg::out_item_t               rsp_item_reg;
    logic [ltgs_pkg::TILE_W-1:0]       tile_reg;
    logic [ltgs_pkg::TILE_W-1:0]       tile_next;
    logic [ltgs_pkg::MASK_W-1:0]       survive_mask_reg;
    logic [ltgs_pkg::MASK_W-1:0]       birth_mask_reg;
    logic                              survive_alone_reg;
    logic                              advance;
    logic [5:0][5:0]                   grid;
    logic [15:0][ltgs_pkg::COUNT_W-1:0] count;
    logic [ltgs_pkg::TILE_W-1:0]       step_tile;

    // The result register takes a new item whenever it is empty or draining.
    assign advance   = !rsp_valid_reg || rsp.ready;
    assign req.ready = !s1_valid_reg || advance;
    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_item_reg;

    // Build the 6x6 neighborhood: tile in the middle, border ring around it.
    always_comb
    begin
        grid = '0;
        grid[0][0] = s1_item_reg.corners[0];
        grid[0][5] = s1_item_reg.corners[1];
        grid[5][0] = s1_item_reg.corners[2];
        grid[5][5] = s1_item_reg.corners[3];
        for (int i = 0; i < 4; i++)
        begin
            grid[0][i+1] = s1_item_reg.north_south[4+i];
            grid[5][i+1] = s1_item_reg.north_south[i];
            grid[i+1][0] = s1_item_reg.east_west[i];
            grid[i+1][5] = s1_item_reg.east_west[4+i];
            for (int j = 0; j < 4; j++)
            begin
                grid[i+1][j+1] = tile_reg[4*i+j];
            end
        end
    end

    // Each cell counts its eight neighbors.
    always_comb
    begin
        count = '0;
        for (int r = 0; r < 4; r++)
        begin
            for (int c = 0; c < 4; c++)
            begin
                for (int dr = 0; dr < 3; dr++)
                begin
                    for (int dc = 0; dc < 3; dc++)
                    begin
                        if (dr != 1 || dc != 1)
                        begin
                            count[4*r+c] = count[4*r+c] + {3'b000, grid[r+dr][c+dc]};
                        end
                    end
                end
            end
        end
    end

    // Apply the rules; a dead cell with no neighbors always stays dead.
    always_comb
    begin
        step_tile = '0;
        for (int k = 0; k < 16; k++)
        begin
            if (count[k] == '0)
            begin
                step_tile[k] = tile_reg[k] & survive_alone_reg;
            end
            else if (tile_reg[k])
            begin
                step_tile[k] = survive_mask_reg[3'(count[k] - 4'd1)];
            end
            else
            begin
                step_tile[k] = birth_mask_reg[3'(count[k] - 4'd1)];
            end
        end
    end

    // Select the new tile by operation.
    always_comb
    begin
        case (s1_item_reg.op)
            ltgs_pkg::OP_LOAD: tile_next = s1_item_reg.load_cells;
            ltgs_pkg::OP_STEP: tile_next = step_tile;
            default:           tile_next = tile_reg;
        endcase
    end

    // Pipeline control and the tile state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
            tile_reg      <= '0;
        end
        else
        begin
            if (req.ready)
            begin
                s1_valid_reg <= req.valid;
            end
            if (advance)
            begin
                rsp_valid_reg <= s1_valid_reg;
                if (s1_valid_reg)
                begin
                    tile_reg <= tile_next;
                end
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            s1_item_reg <= req.data;
        end
        if (advance && s1_valid_reg)
        begin
            rsp_item_reg.cells     <= tile_next;
            rsp_item_reg.all_dead  <= (tile_next == '0);
            rsp_item_reg.unchanged <= (tile_next == tile_reg);
        end
    end

    // Rule registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            survive_mask_reg  <= ltgs_pkg::SURVIVE_MASK_RST;
            birth_mask_reg    <= ltgs_pkg::BIRTH_MASK_RST;
            survive_alone_reg <= ltgs_pkg::SURVIVE_ALONE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ltgs_pkg::CFG_SURVIVE_MASK:  survive_mask_reg  <= cfg_wdata;
                ltgs_pkg::CFG_BIRTH_MASK:    birth_mask_reg    <= cfg_wdata;
                ltgs_pkg::CFG_SURVIVE_ALONE: survive_alone_reg <= cfg_wdata[0];
                default:                     ;
            endcase
        end
    end

endmodule

// ----- hw/rtl/ltgs_chk.sv -----
// Port-level checks for the life tile unit.
module ltgs_chk
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          req_valid,
    input logic                          req_ready,
    input logic                          req_op,
    input logic [ltgs_pkg::TILE_W-1:0]   req_load_cells,
    input logic                          rsp_valid,
    input logic                          rsp_ready,
    input logic [ltgs_pkg::TILE_W-1:0]   rsp_cells,
    input logic                          rsp_all_dead,
    input logic                          rsp_unchanged
);

    // A stalled result holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_cells)
            && $stable(rsp_all_dead) && $stable(rsp_unchanged))
        else $error("stalled result changed");

    // The all-dead flag follows the tile it comes with.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_all_dead == (rsp_cells == '0)))
        else $error("all_dead flag disagrees with cells");

    // With an empty result register the unit always takes input.
    assert property (@(posedge clk) disable iff (!rst_n)
        !rsp_valid |-> req_ready)
        else $error("input blocked while output is empty");

    // A load reaches the output through the input and result registers when the receiver is ready.
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready && (req_op == ltgs_pkg::OP_LOAD)) ##1 rsp_ready
            |=> rsp_valid && (rsp_cells == $past(req_load_cells, 2)))
        else $error("loaded tile not returned");

    // A result that follows a transfer and reports unchanged shows the same tile as the transferred one.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_ready ##1 rsp_valid && rsp_unchanged
            |-> rsp_cells == $past(rsp_cells))
        else $error("unchanged flag set on a different tile");

endmodule

bind life_tile_generation_step_unit ltgs_chk u_ltgs_chk
(
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .req_op         (req.data.op),
    .req_load_cells (req.data.load_cells),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_cells      (rsp.data.cells),
    .rsp_all_dead   (rsp.data.all_dead),
    .rsp_unchanged  (rsp.data.unchanged)
);
